### design/gpms_pkg.sv
// ----------------------------------------------------------------------------
// gpms_pkg: shared definitions for the goal-to-polar motion sequencer
// Holds the field widths, event and command codes, the fixed-point constants
// and the elementary angle table used by the vectoring unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpms_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_STEPS    = 24;
  localparam int NUM_STEPS    = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int CNT_W        = $clog2(NUM_STEPS);
  localparam int ATAN_IDX_W   = $clog2(MAX_STEPS);

  localparam int GUARD_SHIFT  = 16;
  localparam int X_W          = COORD_WIDTH + GUARD_SHIFT + 2;
  localparam int Z_W          = 32;
  localparam int MAG_SHIFT    = 8;
  localparam int SHR_W        = X_W - 1 - MAG_SHIFT;
  localparam int KINV_W       = 20;
  localparam int PROD_W       = SHR_W + KINV_W;
  localparam int ROUND_SHIFT  = 28;
  localparam int DFULL_W      = PROD_W + 1 - ROUND_SHIFT;
  localparam int ANGLE_SHIFT  = 16;

  localparam int KIND_W       = 2;
  localparam int DIST_W       = 16;
  localparam int VALUE_W      = 17;

  localparam logic [KINV_W-1:0]         KINV_Q20    = 20'd636752;
  localparam logic signed [Z_W-1:0]     HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [VALUE_W-1:0] PI_Q13      = 17'sd25736;
  localparam logic signed [VALUE_W-1:0] NEG_PI_Q13  = -17'sd25736;

  localparam logic [KIND_W-1:0] KIND_GOAL       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROT_DONE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRANS_DONE = 2'd2;

  localparam logic [KIND_W-1:0] CMD_ROTATE    = 2'd0;
  localparam logic [KIND_W-1:0] CMD_TRANSLATE = 2'd1;
  localparam logic [KIND_W-1:0] CMD_REACHED   = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distance;
    logic [VALUE_W-1:0] angle;
  } gpms_cordic_res_t;

  // Elementary angles atan(2^-i) in Q29 radians.
  function automatic logic [Z_W-1:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
    logic [Z_W-1:0] val;
    case (idx)
      5'd0:    val = 32'd421657428;
      5'd1:    val = 32'd248918915;
      5'd2:    val = 32'd131521919;
      5'd3:    val = 32'd66762580;
      5'd4:    val = 32'd33510843;
      5'd5:    val = 32'd16771757;
      5'd6:    val = 32'd8387926;
      5'd7:    val = 32'd4194219;
      5'd8:    val = 32'd2097141;
      5'd9:    val = 32'd1048575;
      5'd10:   val = 32'd524288;
      5'd11:   val = 32'd262144;
      5'd12:   val = 32'd131072;
      5'd13:   val = 32'd65536;
      5'd14:   val = 32'd32768;
      5'd15:   val = 32'd16384;
      5'd16:   val = 32'd8192;
      5'd17:   val = 32'd4096;
      5'd18:   val = 32'd2048;
      5'd19:   val = 32'd1024;
      5'd20:   val = 32'd512;
      5'd21:   val = 32'd256;
      5'd22:   val = 32'd128;
      5'd23:   val = 32'd64;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### design/gpms_in_if.sv
// ----------------------------------------------------------------------------
// gpms_in_if: event channel of the motion sequencer
// Carries one event item (kind and goal coordinates) with a valid/ready
// handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gpms_in_if;
  import gpms_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  coord_t            goal_x;
  coord_t            goal_y;

  modport source (output valid, output kind, output goal_x, output goal_y, input ready);
  modport sink   (input valid, input kind, input goal_x, input goal_y, output ready);
endinterface

`default_nettype wire

### design/gpms_out_if.sv
// ----------------------------------------------------------------------------
// gpms_out_if: command channel of the motion sequencer
// Carries one command item (kind and value) with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gpms_out_if;
  import gpms_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         command_kind;
  logic signed [VALUE_W-1:0] command_value;

  modport source (output valid, output command_kind, output command_value, input ready);
  modport sink   (input valid, input command_kind, input command_value, output ready);
endinterface

`default_nettype wire

### design/gpms_cordic.sv
// ----------------------------------------------------------------------------
// gpms_cordic: iterative CORDIC vectoring unit
// One micro-rotation per cycle on a shared add/shift datapath, then a gain
// correction multiply and a rounding and saturation step for distance and angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpms_cordic (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  gpms_pkg::coord_t          gx_i,
  input  gpms_pkg::coord_t          gy_i,
  output gpms_pkg::gpms_cordic_res_t res_o
);
  import gpms_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ITER = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int EXT_W = X_W - COORD_WIDTH - GUARD_SHIFT;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_STEPS - 1);
  localparam logic signed [Z_W:0] Z_ROUND = (Z_W+1)'(1) << (ANGLE_SHIFT - 1);
  localparam logic [PROD_W:0] P_ROUND = (PROD_W+1)'(1) << (ROUND_SHIFT - 1);

  logic [1:0]              st_q, st_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [X_W-1:0]   x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]   z_q, z_d;
  logic [PROD_W-1:0]       prod_q, prod_d;

  logic signed [X_W-1:0]   gx_ext, gy_ext, dx, dy;
  logic [Z_W-1:0]          atan_val;
  logic                    y_pos, y_neg;
  logic [SHR_W-1:0]        mag_shr;
  logic [PROD_W:0]         prod_rnd;
  logic [DFULL_W-1:0]      dist_full;
  logic signed [Z_W:0]     z_rnd;
  logic signed [VALUE_W-1:0] ang_raw, ang_sat;

  assign gx_ext   = $signed({{EXT_W{gx_i[COORD_WIDTH-1]}}, gx_i, {GUARD_SHIFT{1'b0}}});
  assign gy_ext   = $signed({{EXT_W{gy_i[COORD_WIDTH-1]}}, gy_i, {GUARD_SHIFT{1'b0}}});
  assign dx       = y_q >>> cnt_q;
  assign dy       = x_q >>> cnt_q;
  assign atan_val = atan_q29(ATAN_IDX_W'(cnt_q));
  assign y_neg    = y_q[X_W-1];
  assign y_pos    = !y_q[X_W-1] && (y_q != '0);
  assign mag_shr  = x_q[X_W-1] ? '0 : x_q[X_W-2:MAG_SHIFT];

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    prod_d = prod_q;
    case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          st_d  = ST_ITER;
          if (gx_ext[X_W-1]) begin
            if (!gy_ext[X_W-1]) begin
              x_d = gy_ext;
              y_d = -gx_ext;
              z_d = HALF_PI_Q29;
            end else begin
              x_d = -gy_ext;
              y_d = gx_ext;
              z_d = -HALF_PI_Q29;
            end
          end else begin
            x_d = gx_ext;
            y_d = gy_ext;
            z_d = '0;
          end
        end
      end
      ST_ITER: begin
        if (y_pos) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + $signed(atan_val);
        end else if (y_neg) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - $signed(atan_val);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = PROD_W'(mag_shr) * PROD_W'(KINV_Q20);
        st_d   = ST_FIN;
      end
      ST_FIN: begin
        st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    prod_rnd  = {1'b0, prod_q} + P_ROUND;
    dist_full = prod_rnd[PROD_W:ROUND_SHIFT];
    z_rnd     = {z_q[Z_W-1], z_q} + Z_ROUND;
    ang_raw   = z_rnd[Z_W:ANGLE_SHIFT];
    if (ang_raw > PI_Q13) begin
      ang_sat = PI_Q13;
    end else if (ang_raw < NEG_PI_Q13) begin
      ang_sat = NEG_PI_Q13;
    end else begin
      ang_sat = ang_raw;
    end
    res_o.done     = (st_q == ST_FIN);
    res_o.distance = (|dist_full[DFULL_W-1:DIST_W]) ? '1 : dist_full[DIST_W-1:0];
    res_o.angle    = ang_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    prod_q <= prod_d;
  end

endmodule

`default_nettype wire

### design/goal_to_polar_motion_sequencer.sv
// ----------------------------------------------------------------------------
// goal_to_polar_motion_sequencer: turns goal and acknowledgement events into
// rotate, translate and goal-reached commands.
//
// Events enter on in_i and commands leave on out_o, both valid/ready channels.
// A new goal taken while idle is converted to polar form by an iterative
// CORDIC unit that performs one micro-rotation per cycle, followed by the
// gain multiply and a rounding step. Goals that arrive while a move is
// still in progress are dropped. in_i is not ready until the current item
// has reached the output register.
// Results are held in a single output register, so a new item can be taken
// while the previous command waits; if the receiver stalls, the next result
// waits in the sequencer until the output register is free.
// Reset clears both busy flags, the stored distance and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module goal_to_polar_motion_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  gpms_in_if.sink           in_i,
  gpms_out_if.source        out_o
);
  import gpms_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CORDIC = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0]          state_q, state_d;
  logic                rotating_q, rotating_d;
  logic                translating_q, translating_d;
  logic [DIST_W-1:0]   pend_dist_q, pend_dist_d;
  logic [KIND_W-1:0]   res_kind_q, res_kind_d;
  logic [VALUE_W-1:0]  res_val_q, res_val_d;
  logic                out_valid_q, out_valid_d;
  logic [KIND_W-1:0]   out_kind_q, out_kind_d;
  logic [VALUE_W-1:0]  out_val_q, out_val_d;

  logic                accept;
  logic                cordic_start;
  gpms_cordic_res_t    cordic_res;

  assign in_i.ready          = (state_q == S_IDLE);
  assign accept              = in_i.valid && in_i.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.command_kind  = out_kind_q;
  assign out_o.command_value = $signed(out_val_q);

  gpms_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .gx_i    (in_i.goal_x),
    .gy_i    (in_i.goal_y),
    .res_o   (cordic_res)
  );

  always_comb begin
    state_d       = state_q;
    rotating_d    = rotating_q;
    translating_d = translating_q;
    pend_dist_d   = pend_dist_q;
    res_kind_d    = res_kind_q;
    res_val_d     = res_val_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_kind_d    = out_kind_q;
    out_val_d     = out_val_q;
    cordic_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.kind)
            KIND_GOAL: begin
              if (!rotating_q && !translating_q) begin
                if (in_i.goal_x == '0 && in_i.goal_y == '0) begin
                  res_kind_d = CMD_REACHED;
                  res_val_d  = '0;
                  state_d    = S_EMIT;
                end else begin
                  cordic_start = 1'b1;
                  state_d      = S_CORDIC;
                end
              end
            end
            KIND_ROT_DONE: begin
              rotating_d = 1'b0;
              res_kind_d = CMD_TRANSLATE;
              res_val_d  = VALUE_W'(pend_dist_q);
              state_d    = S_EMIT;
            end
            KIND_TRANS_DONE: begin
              translating_d = 1'b0;
              res_kind_d    = CMD_REACHED;
              res_val_d     = '0;
              state_d       = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CORDIC: begin
        if (cordic_res.done) begin
          pend_dist_d   = cordic_res.distance;
          rotating_d    = 1'b1;
          translating_d = 1'b1;
          res_kind_d    = CMD_ROTATE;
          res_val_d     = cordic_res.angle;
          state_d       = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_kind_d  = res_kind_q;
          out_val_d   = res_val_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rotating_q    <= 1'b0;
      translating_q <= 1'b0;
      pend_dist_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rotating_q    <= rotating_d;
      translating_q <= translating_d;
      pend_dist_q   <= pend_dist_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= res_kind_d;
    res_val_q  <= res_val_d;
    out_kind_q <= out_kind_d;
    out_val_q  <= out_val_d;
  end

endmodule

`default_nettype wire
